// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

  // Fixed field widths
  localparam int unsigned ID_W       = 8;
  localparam int unsigned IN_BURST_W = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned LEVEL_W    = 5;

  // Request kinds
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RAN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

  // Per-cycle operation on the ready queue.
  // park_push: hold the park data at the tail slot in a side register and
  // write the write data one slot behind it (two entries in, one write).
  typedef struct packed {
    logic pop;
    logic push;
    logic park_push;
  } rrts_qcmd_t;

endpackage

// ----- rtl/rrts_ready_queue.sv -----
module rrts_ready_queue import rrts_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned BURST_BITS = 16,
  localparam int unsigned IDX_W     = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrts_qcmd_t            cmd,
  input  logic [ID_W-1:0]       wr_id,
  input  logic [BURST_BITS-1:0] wr_left,
  input  logic [ID_W-1:0]       park_id,
  input  logic [BURST_BITS-1:0] park_left,
  output logic [ID_W-1:0]       head_id,
  output logic [BURST_BITS-1:0] head_left,
  output logic [CNT_W-1:0]      count
);

  logic [ID_W-1:0]       id_mem   [DEPTH];
  logic [BURST_BITS-1:0] left_mem [DEPTH];

  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  park_vld_r, park_vld_nxt;
  logic [IDX_W-1:0]      park_slot_r;
  logic [ID_W-1:0]       park_id_r;
  logic [BURST_BITS-1:0] park_left_r;
  logic [ID_W-1:0]       rd_id_r;
  logic [BURST_BITS-1:0] rd_left_r;

  logic [IDX_W-1:0]      head_p1, tail_p1, tail_p2, wr_addr;
  logic                  wr_en, park_hit;

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  assign head_p1  = inc_idx(head_r);
  assign tail_p1  = inc_idx(tail_r);
  assign tail_p2  = inc_idx(tail_p1);
  assign wr_en    = cmd.push | cmd.park_push;
  assign wr_addr  = cmd.park_push ? tail_p1 : tail_r;
  assign park_hit = park_vld_r && (head_r == park_slot_r);

  assign head_nxt = cmd.pop ? head_p1 : head_r;

  always_comb begin
    priority if (cmd.park_push) begin
      tail_nxt = tail_p2;
    end else if (cmd.push) begin
      tail_nxt = tail_p1;
    end else begin
      tail_nxt = tail_r;
    end
  end

  assign count_nxt = count_r - CNT_W'(cmd.pop) + CNT_W'(cmd.push)
                     + (cmd.park_push ? CNT_W'(2) : CNT_W'(0));

  always_comb begin
    priority if (cmd.park_push) begin
      park_vld_nxt = 1'b1;
    end else if (cmd.pop && park_hit) begin
      park_vld_nxt = 1'b0;
    end else begin
      park_vld_nxt = park_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      park_vld_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      park_vld_r <= park_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.park_push) begin
      park_slot_r <= tail_r;
      park_id_r   <= park_id;
      park_left_r <= park_left;
    end
  end

  // Storage with one write port and one registered read port on the next head;
  // a same-cycle write to that slot is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]   <= wr_id;
      left_mem[wr_addr] <= wr_left;
    end
    if (wr_en && (wr_addr == head_nxt)) begin
      rd_id_r   <= wr_id;
      rd_left_r <= wr_left;
    end else begin
      rd_id_r   <= id_mem[head_nxt];
      rd_left_r <= left_mem[head_nxt];
    end
  end

  assign head_id   = park_hit ? park_id_r   : rd_id_r;
  assign head_left = park_hit ? park_left_r : rd_left_r;
  assign count     = count_r;

endmodule

// ----- rtl/round_robin_tick_scheduler_core.sv -----
// Channel   Ports                                               Accepted when
// --------  --------------------------------------------------  -------------------------
// request   in_valid, in_stall, in_command, in_job_id,          in_valid && !in_stall
//           in_burst_length
// result    out_valid, out_stall, out_status, out_job_id_out,   out_valid && !out_stall
//           out_queue_level
//
// One request per cycle sustained while out_stall is low; a taken request waits in the
// request register, is processed from there, and its result is held in the result register
// until taken. Processing is a single pass from the request register through the ready queue
// (one write port, one registered head read) into the result register.
// rst_n is synchronous and active low; queue storage needs no clearing pass.
// out_stall holds a valid result in the result register and, only when a request is also
// waiting in the request register, raises in_stall in the same cycle.
module round_robin_tick_scheduler_core import rrts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BURST_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [ID_W-1:0]       in_job_id,
  input  logic [IN_BURST_W-1:0] in_burst_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_job_id_out,
  output logic [LEVEL_W-1:0]    out_queue_level
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request register
  logic                  in_vld_r;
  logic                  in_cmd_r;
  logic [ID_W-1:0]       in_id_r;
  logic [BURST_BITS-1:0] in_burst_r;

  // Running slot
  logic                  run_vld_r, run_vld_nxt;
  logic [ID_W-1:0]       run_id_r, run_id_nxt;
  logic [BURST_BITS-1:0] run_left_r, run_left_nxt;

  // Result register
  logic                  out_vld_r;
  logic [STATUS_W-1:0]   out_status_r, status_nxt;
  logic [ID_W-1:0]       out_id_r, id_nxt;
  logic [LEVEL_W-1:0]    out_level_r;
  logic [CNT_W-1:0]      level_cnt;

  // Ready queue interface
  rrts_qcmd_t            qcmd;
  logic [ID_W-1:0]       q_wr_id, q_head_id;
  logic [BURST_BITS-1:0] q_wr_left, q_head_left;
  logic [CNT_W-1:0]      q_count;

  // Tick helpers
  logic                  go;
  logic                  has_wait, rot, cur_vld, requeue;
  logic [ID_W-1:0]       cur_id;
  logic [BURST_BITS-1:0] cur_left, cur_dec;
  logic [CNT_W-1:0]      cnt_mid;

  // Process the held request whenever the result register is free or draining.
  assign go       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_cmd_r   <= in_command;
      in_id_r    <= in_job_id;
      in_burst_r <= BURST_BITS'(in_burst_length);
    end
  end

  // A held job at tick start rotates with the head whenever jobs are waiting;
  // otherwise an idle slot takes the head.
  assign has_wait = (q_count != '0);
  assign rot      = run_vld_r && has_wait;
  assign cur_vld  = run_vld_r || has_wait;
  assign cur_id   = has_wait ? q_head_id   : run_id_r;
  assign cur_left = has_wait ? q_head_left : run_left_r;
  assign cur_dec  = cur_left - BURST_BITS'(1);
  assign cnt_mid  = (!run_vld_r && has_wait) ? (q_count - CNT_W'(1)) : q_count;
  assign requeue  = (cnt_mid != '0) && (cnt_mid < CNT_W'(QUEUE_DEPTH));

  always_comb begin
    qcmd         = '0;
    q_wr_id      = in_id_r;
    q_wr_left    = in_burst_r;
    run_vld_nxt  = run_vld_r;
    run_id_nxt   = run_id_r;
    run_left_nxt = run_left_r;
    status_nxt   = ST_IDLE;
    id_nxt       = '0;
    level_cnt    = q_count;
    if (go) begin
      unique case (in_cmd_r)
        CMD_ARRIVE: begin
          id_nxt = in_id_r;
          if (q_count >= CNT_W'(QUEUE_DEPTH)) begin
            status_nxt = ST_DROPPED;
          end else begin
            qcmd.push  = 1'b1;
            status_nxt = ST_QUEUED;
            level_cnt  = q_count + CNT_W'(1);
          end
        end
        CMD_TICK: begin
          if (cur_vld) begin
            id_nxt     = cur_id;
            run_id_nxt = cur_id;
            qcmd.pop   = has_wait;
            level_cnt  = cnt_mid;
            if (cur_left <= BURST_BITS'(1)) begin
              // Finish: a rotated job still goes to the tail.
              status_nxt   = ST_FINISHED;
              run_vld_nxt  = 1'b0;
              run_left_nxt = '0;
              qcmd.push    = rot;
              q_wr_id      = run_id_r;
              q_wr_left    = run_left_r;
            end else begin
              status_nxt   = ST_RAN;
              run_left_nxt = cur_dec;
              if (requeue) begin
                // Requeue behind others; a rotated job parks one slot ahead.
                run_vld_nxt    = 1'b0;
                level_cnt      = cnt_mid + CNT_W'(1);
                q_wr_id        = cur_id;
                q_wr_left      = cur_dec;
                qcmd.push      = !rot;
                qcmd.park_push = rot;
              end else begin
                // Hold the job running: queue empty or full.
                run_vld_nxt = 1'b1;
                qcmd.push   = rot;
                q_wr_id     = run_id_r;
                q_wr_left   = run_left_r;
              end
            end
          end
        end
      endcase
    end
  end

  rrts_ready_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .BURST_BITS (BURST_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (qcmd),
    .wr_id     (q_wr_id),
    .wr_left   (q_wr_left),
    .park_id   (run_id_r),
    .park_left (run_left_r),
    .head_id   (q_head_id),
    .head_left (q_head_left),
    .count     (q_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_vld_r  <= 1'b0;
      run_id_r   <= '0;
      run_left_r <= '0;
    end else if (go) begin
      run_vld_r  <= run_vld_nxt;
      run_id_r   <= run_id_nxt;
      run_left_r <= run_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= status_nxt;
      out_id_r     <= id_nxt;
      out_level_r  <= LEVEL_W'(level_cnt);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_status_r;
  assign out_job_id_out  = out_id_r;
  assign out_queue_level = out_level_r;

  // An arrival never touches the running slot.
  a_arrive_keeps_running: assert property (@(posedge clk) disable iff (!rst_n)
    go && (in_cmd_r == CMD_ARRIVE) |=> $stable(run_vld_r) && $stable(run_id_r))
    else $error("arrival changed the running slot");

  // A finished job leaves the running slot empty.
  a_finish_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    go && (in_cmd_r == CMD_TICK) && (status_nxt == ST_FINISHED) |=> !run_vld_r)
    else $error("running slot still busy after finish");

  // An arrival is dropped only when the queue is full.
  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    go && (in_cmd_r == CMD_ARRIVE) && (q_count < CNT_W'(QUEUE_DEPTH))
    |=> out_status == ST_QUEUED)
    else $error("arrival dropped with room in the queue");

  // Back-pressure only comes from a held, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("request stalled without a stalled result");

endmodule

// ----- tb/round_robin_tick_scheduler_core_tb.sv -----
module round_robin_tick_scheduler_core_tb import rrts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Scheduler geometry used by the prediction; matches the instance defaults.
  localparam int unsigned TB_QUEUE_DEPTH = 16;
  localparam int unsigned TB_BURST_BITS  = 16;

  // Total random requests after the directed part.
  localparam int unsigned RANDOM_REQUESTS = 1950;

  // Cycles without any handshake on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;

  // Longest idle gap either side inserts in front of a request or a result.
  localparam int unsigned MAX_GAP = 14;

  // One predicted result, field by field as the result channel carries it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     job_id;
    logic [LEVEL_W-1:0]  level;
  } sched_result_t;

  // Scoreboard: mirrors the ready ring and the running slot, turns every
  // accepted request into one expected result, and compares results in order.
  class ready_queue_sb;
    logic [ID_W-1:0]          ring_id   [TB_QUEUE_DEPTH];
    logic [TB_BURST_BITS-1:0] ring_left [TB_QUEUE_DEPTH];
    int unsigned              head;
    int unsigned              tail;
    int unsigned              waiting;
    bit                       running;
    logic [ID_W-1:0]          run_id;
    logic [TB_BURST_BITS-1:0] run_left;
    sched_result_t            expected_q [$];
    int unsigned              errors;

    function new();
      head     = 0;
      tail     = 0;
      waiting  = 0;
      running  = 1'b0;
      run_id   = '0;
      run_left = '0;
      errors   = 0;
    endfunction

    function void enqueue(logic [ID_W-1:0] id, logic [TB_BURST_BITS-1:0] left);
      ring_id[tail]   = id;
      ring_left[tail] = left;
      tail            = (tail + 1) % TB_QUEUE_DEPTH;
      waiting++;
    endfunction

    function void dequeue(output logic [ID_W-1:0] id,
                          output logic [TB_BURST_BITS-1:0] left);
      id      = ring_id[head];
      left    = ring_left[head];
      head    = (head + 1) % TB_QUEUE_DEPTH;
      waiting--;
    endfunction

    // Advance the mirror by one accepted request and queue its result.
    function void note_request(logic cmd, logic [ID_W-1:0] id,
                               logic [IN_BURST_W-1:0] burst);
      sched_result_t            res;
      logic [ID_W-1:0]          next_id;
      logic [TB_BURST_BITS-1:0] next_left;
      res = '0;
      if (cmd == CMD_ARRIVE) begin
        res.job_id = id;
        if (waiting >= TB_QUEUE_DEPTH) begin
          res.status = ST_DROPPED;
        end else begin
          enqueue(id, burst[TB_BURST_BITS-1:0]);
          res.status = ST_QUEUED;
        end
      end else begin
        // A job still holding the slot rotates through the ring.
        if (running && waiting > 0) begin
          dequeue(next_id, next_left);
          enqueue(run_id, run_left);
          run_id   = next_id;
          run_left = next_left;
        end
        if (!running && waiting > 0) begin
          dequeue(run_id, run_left);
          running = 1'b1;
        end
        if (!running) begin
          res.status = ST_IDLE;
        end else begin
          res.job_id = run_id;
          if (run_left <= 1) begin
            run_left   = '0;
            running    = 1'b0;
            res.status = ST_FINISHED;
          end else begin
            run_left--;
            res.status = ST_RAN;
            // Hold the job in the slot when the ring is full or empty.
            if (waiting > 0 && waiting < TB_QUEUE_DEPTH) begin
              enqueue(run_id, run_left);
              running = 1'b0;
            end
          end
        end
      end
      res.level = waiting[LEVEL_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] job_id,
                               logic [LEVEL_W-1:0] level);
      sched_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d job=%0d level=%0d",
                 $time, status, job_id, level);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (status !== exp_res.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, exp_res.status, status);
          errors++;
        end
        if (job_id !== exp_res.job_id) begin
          $display("%0t: job_id_out mismatch: expected %0d actual %0d",
                   $time, exp_res.job_id, job_id);
          errors++;
        end
        if (level !== exp_res.level) begin
          $display("%0t: queue_level mismatch: expected %0d actual %0d",
                   $time, exp_res.level, level);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_command      = CMD_TICK;
  logic [ID_W-1:0]       in_job_id       = '0;
  logic [IN_BURST_W-1:0] in_burst_length = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_job_id_out;
  logic [LEVEL_W-1:0]    out_queue_level;

  // Set during phases that run both channels back to back with no gaps.
  bit calm = 1'b0;

  ready_queue_sb sb = new();

  round_robin_tick_scheduler_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_job_id       (in_job_id),
    .in_burst_length (in_burst_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_job_id_out  (out_job_id_out),
    .out_queue_level (out_queue_level)
  );

  always #5 clk = ~clk;

  // Sample both channels on the edge, before any of this edge's updates land:
  // note the request first so a result arriving with its request would still find its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_command, in_job_id, in_burst_length);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_status, out_job_id_out, out_queue_level);
      end
    end
  end

  // Drive one request: idle for a drawn gap, present it, hold it until taken.
  // Valid is only dropped when a gap follows, so back-to-back requests keep
  // a single assignment per edge.
  task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                              input logic [IN_BURST_W-1:0] burst);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_job_id       <= id;
    in_burst_length <= burst;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_arrival(input logic [ID_W-1:0] id, input logic [IN_BURST_W-1:0] burst);
    send_request(CMD_ARRIVE, id, burst);
  endtask

  // Ticks carry random job and burst fields, which the block must ignore.
  task automatic send_tick();
    send_request(CMD_TICK, ID_W'($urandom), IN_BURST_W'($urandom));
  endtask

  // Result side: stall for a drawn number of cycles, then take one result.
  initial begin
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("round_robin_tick_scheduler_core regression: fail");
    $finish;
  end

  initial begin
    int unsigned left_to_send;
    int unsigned phase_len;
    int unsigned arrive_pct;
    logic [IN_BURST_W-1:0] burst;

    // Hold reset, then release it.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Tick on an empty scheduler: idle result.
    send_tick();
    // Zero burst: runs a single tick and finishes.
    send_arrival(8'd0, 16'd0);
    send_tick();
    // Largest id and burst; it runs alone and keeps the slot.
    send_arrival(8'd255, 16'hFFFF);
    send_tick();
    // Fill the ring behind the running job, then one arrival that gets dropped.
    for (int unsigned j = 1; j <= TB_QUEUE_DEPTH; j++) begin
      send_arrival(ID_W'(j), (j % 2 == 1) ? 16'd2 : 16'd3);
    end
    send_arrival(8'h5A, 16'h5A5A);
    // Full ring: the rotated-in job cannot be requeued and holds the slot.
    send_tick();
    send_tick();
    send_tick();

    // Random part: phases with different arrival rates so the ring fills,
    // overflows and drains; some phases run without any idling.
    left_to_send = RANDOM_REQUESTS;
    while (left_to_send > 0) begin
      phase_len = $urandom_range(50, 150);
      case ($urandom_range(0, 4))
        0:       arrive_pct = 10;
        1:       arrive_pct = 25;
        2:       arrive_pct = 35;
        3:       arrive_pct = 50;
        default: arrive_pct = 80;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < phase_len && left_to_send > 0; k++) begin
        if ($urandom_range(0, 99) < arrive_pct) begin
          // Keep most bursts short; a rare full-width burst stays around for good.
          burst = ($urandom_range(0, 299) == 0) ? IN_BURST_W'($urandom)
                                                : IN_BURST_W'($urandom_range(0, 6));
          send_arrival(ID_W'($urandom), burst);
        end else begin
          send_tick();
        end
        left_to_send--;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: let the last request be noted, wait for every expected result,
    // then let the pipeline settle.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("round_robin_tick_scheduler_core regression: pass");
    end else begin
      $display("round_robin_tick_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rrts_pkg.sv
rtl/rrts_ready_queue.sv
rtl/round_robin_tick_scheduler_core.sv
tb/round_robin_tick_scheduler_core_tb.sv
